### hdl/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the masked sprite blitter: field widths,
// command codes, register indexes, controller states and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msb_pkg;

    // Default sizing of the frame store and sprite mask
    localparam int FB_MAX_WIDTH_DEF  = 256;
    localparam int FB_MAX_HEIGHT_DEF = 256;
    localparam int SPRITE_MAX_DEF    = 16;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int POS_W       = 10;
    localparam int COLOR_W     = 24;
    localparam int ROW_IDX_W   = 4;
    localparam int MASK_COLS   = 16;
    localparam int PIXEL_W     = 32;
    localparam int FB_DIM_W    = 9;
    localparam int SPR_DIM_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    // frame column/row as position plus sprite offset (sprite offset < 32)
    localparam int FX_W        = POS_W + 1;

    localparam logic [7:0]           ALPHA_FULL      = 8'd255;
    localparam logic [FB_DIM_W-1:0]  FB_WIDTH_RST    = 9'd256;
    localparam logic [FB_DIM_W-1:0]  FB_HEIGHT_RST   = 9'd256;
    localparam logic [SPR_DIM_W-1:0] SPRITE_W_RST    = 5'd11;
    localparam logic [SPR_DIM_W-1:0] SPRITE_H_RST    = 5'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DRAW  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_WIDTH  = 2'd0,
        CFG_FB_HEIGHT = 2'd1,
        CFG_SPR_WIDTH = 2'd2,
        CFG_SPR_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_MUL,
        ST_CLR_RUN,
        ST_DRW_START,
        ST_DRW_ROW,
        ST_DRW_COL,
        ST_RD_MUL,
        ST_RD_MEM,
        ST_FINISH
    } state_t;

    // Operand select for the shared multiplier
    typedef enum logic [1:0] {
        MUL_FRAME,      // width * height, clear length
        MUL_ROW,        // frame row * width, draw row base
        MUL_READ        // read row * width
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_load;
        mul_sel_t mul_sel;
        logic     clr_step;
        logic     drw_init;
        logic     col_step;
        logic     row_step;
        logic     mem_rd;
        logic     push;
    } ctl_t;

    typedef struct packed {
        logic clr_empty;
        logic clr_last;
        logic draw_empty;
        logic col_last;
        logic row_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/masked_sprite_blitter_top.sv
// ----------------------------------------------------------------------------
// masked_sprite_blitter_top
// Framebuffer engine: 24-bit RGB frame store with clear, masked sprite draw
// (vertically flipped, clipped to the active frame) and pixel read-back.
//
// Input channel (in_valid / in_stall) carries one command beat: load mask
// row, clear frame, draw sprite or read pixel. Every command yields exactly
// one output beat (out_valid / out_stall); only a read carries data, packed
// RGBA with alpha 255, plus an out-of-range flag.
// One command is worked at a time; in_stall is high while it runs.
// Steps from accept to result beat:
//   load  mask row write, result
//   read  row multiply, frame store read, result
//   clear frame-size multiply, then one store write per cycle over the active
//         frame (no writes for an empty frame), result
//   draw  one mask cell per cycle plus a row-base multiply per sprite row, result
// The result sits in an output register, so the next command is accepted
// while it waits; a stalled result only holds the block in its final state.
// Reset clears the controller, output valid and mask, sets the size registers to
// their defaults; the frame store holds nothing defined until a clear or draw writes it.
// Configuration writes are taken any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_sprite_blitter_top
#(
    parameter int FB_MAX_WIDTH  = msb_pkg::FB_MAX_WIDTH_DEF,
    parameter int FB_MAX_HEIGHT = msb_pkg::FB_MAX_HEIGHT_DEF,
    parameter int SPRITE_MAX    = msb_pkg::SPRITE_MAX_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [msb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [msb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [msb_pkg::CMD_W-1:0]       cmd,
    input  wire logic [msb_pkg::POS_W-1:0]       pos_x,
    input  wire logic [msb_pkg::POS_W-1:0]       pos_y,
    input  wire logic [msb_pkg::COLOR_W-1:0]     color_rgb,
    input  wire logic [msb_pkg::ROW_IDX_W-1:0]   row_index,
    input  wire logic [msb_pkg::MASK_COLS-1:0]   row_bits,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [msb_pkg::PIXEL_W-1:0]          read_pixel,
    output logic                                 out_of_range
);

    msb_pkg::ctl_t ctl;
    msb_pkg::sts_t sts;
    logic          busy;

    msb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl),
        .busy     (busy)
    );

    msb_datapath
    #(
        .FB_MAX_WIDTH  (FB_MAX_WIDTH),
        .FB_MAX_HEIGHT (FB_MAX_HEIGHT),
        .SPRITE_MAX    (SPRITE_MAX)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .color_rgb    (color_rgb),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .ctl          (ctl),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .read_pixel   (read_pixel),
        .out_of_range (out_of_range)
    );

    assign in_stall = busy;

    // a result beat is only pushed into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (!out_valid || !out_stall))
        else $error("result pushed over a waiting beat");

    // every accepted command keeps the block busy in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block idle right after accepting a command");

    // a push always shows up as a valid beat
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> out_valid)
        else $error("pushed result not presented");

    // frame store sweeps and draws never run while a command can be accepted
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.clr_step || ctl.col_step) |-> in_stall)
        else $error("frame store written while idle");

endmodule

`default_nettype wire

### hdl/msb_ctrl.sv
// ----------------------------------------------------------------------------
// msb_ctrl
// Command sequencer: accepts one command at a time, steps the datapath
// through clear sweep, per-row draw loop or pixel read, then hands the
// result beat to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_ctrl
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [msb_pkg::CMD_W-1:0]  cmd,
    input  wire msb_pkg::sts_t              sts,
    output msb_pkg::ctl_t                   ctl,
    output logic                            busy
);

    msb_pkg::state_t state_reg;
    msb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.mul_sel  = msb_pkg::MUL_FRAME;
        busy         = 1'b1;

        case (state_reg)
            msb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    case (msb_pkg::cmd_t'(cmd))
                        msb_pkg::CMD_LOAD:  state_next = msb_pkg::ST_FINISH;
                        msb_pkg::CMD_CLEAR: state_next = msb_pkg::ST_CLR_MUL;
                        msb_pkg::CMD_DRAW:  state_next = msb_pkg::ST_DRW_START;
                        msb_pkg::CMD_READ:  state_next = msb_pkg::ST_RD_MUL;
                        default:            state_next = msb_pkg::ST_FINISH;
                    endcase
                end
            end

            msb_pkg::ST_CLR_MUL:
            begin
                ctl.mul_load = 1'b1;
                ctl.mul_sel  = msb_pkg::MUL_FRAME;
                state_next   = msb_pkg::ST_CLR_RUN;
            end

            msb_pkg::ST_CLR_RUN:
            begin
                if (sts.clr_empty)
                begin
                    state_next = msb_pkg::ST_FINISH;
                end
                else
                begin
                    ctl.clr_step = 1'b1;
                    if (sts.clr_last)
                    begin
                        state_next = msb_pkg::ST_FINISH;
                    end
                end
            end

            msb_pkg::ST_DRW_START:
            begin
                ctl.drw_init = 1'b1;
                state_next   = sts.draw_empty ? msb_pkg::ST_FINISH : msb_pkg::ST_DRW_ROW;
            end

            msb_pkg::ST_DRW_ROW:
            begin
                ctl.mul_load = 1'b1;
                ctl.mul_sel  = msb_pkg::MUL_ROW;
                state_next   = msb_pkg::ST_DRW_COL;
            end

            msb_pkg::ST_DRW_COL:
            begin
                ctl.col_step = 1'b1;
                if (sts.col_last)
                begin
                    if (sts.row_last)
                    begin
                        state_next = msb_pkg::ST_FINISH;
                    end
                    else
                    begin
                        ctl.row_step = 1'b1;
                        state_next   = msb_pkg::ST_DRW_ROW;
                    end
                end
            end

            msb_pkg::ST_RD_MUL:
            begin
                ctl.mul_load = 1'b1;
                ctl.mul_sel  = msb_pkg::MUL_READ;
                state_next   = msb_pkg::ST_RD_MEM;
            end

            msb_pkg::ST_RD_MEM:
            begin
                ctl.mem_rd = 1'b1;
                state_next = msb_pkg::ST_FINISH;
            end

            msb_pkg::ST_FINISH:
            begin
                // hold here until the output register can take the beat
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    state_next = msb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = msb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/msb_datapath.sv
// ----------------------------------------------------------------------------
// msb_datapath
// Configuration registers, sprite mask, frame store, shared row-base
// multiplier, sweep counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_datapath
#(
    parameter int FB_MAX_WIDTH  = msb_pkg::FB_MAX_WIDTH_DEF,
    parameter int FB_MAX_HEIGHT = msb_pkg::FB_MAX_HEIGHT_DEF,
    parameter int SPRITE_MAX    = msb_pkg::SPRITE_MAX_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [msb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [msb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [msb_pkg::CMD_W-1:0]       cmd,
    input  wire logic [msb_pkg::POS_W-1:0]       pos_x,
    input  wire logic [msb_pkg::POS_W-1:0]       pos_y,
    input  wire logic [msb_pkg::COLOR_W-1:0]     color_rgb,
    input  wire logic [msb_pkg::ROW_IDX_W-1:0]   row_index,
    input  wire logic [msb_pkg::MASK_COLS-1:0]   row_bits,
    input  wire msb_pkg::ctl_t                   ctl,
    output msb_pkg::sts_t                        sts,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [msb_pkg::PIXEL_W-1:0]          read_pixel,
    output logic                                 out_of_range
);

    localparam int WB        = $clog2(FB_MAX_WIDTH + 1);
    localparam int HB        = $clog2(FB_MAX_HEIGHT + 1);
    localparam int DEPTH     = FB_MAX_WIDTH * FB_MAX_HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam int NW        = $clog2(DEPTH + 1);
    localparam int PW        = HB + WB;
    localparam int SB        = $clog2(SPRITE_MAX + 1);
    localparam int MASK_ROWS = (SPRITE_MAX < msb_pkg::MASK_COLS) ? SPRITE_MAX
                                                                 : msb_pkg::MASK_COLS;
    localparam int RW        = $clog2(MASK_ROWS);
    localparam int RB        = $clog2(MASK_ROWS + 1);
    localparam int CW        = $clog2(msb_pkg::MASK_COLS);
    localparam int CB        = CW + 1;
    localparam int FXW       = msb_pkg::FX_W;

    // configuration
    logic [msb_pkg::FB_DIM_W-1:0]  fb_width_reg;
    logic [msb_pkg::FB_DIM_W-1:0]  fb_height_reg;
    logic [msb_pkg::SPR_DIM_W-1:0] spr_width_reg;
    logic [msb_pkg::SPR_DIM_W-1:0] spr_height_reg;

    // captured command
    msb_pkg::cmd_t                 cmd_reg;
    logic [msb_pkg::POS_W-1:0]     x_reg;
    logic [msb_pkg::POS_W-1:0]     y_reg;
    logic [msb_pkg::COLOR_W-1:0]   color_reg;

    logic [msb_pkg::MASK_COLS-1:0] mask_reg [MASK_ROWS];

    logic [PW-1:0]                 prod_reg;
    logic [AW-1:0]                 clr_cnt_reg;
    logic [CW-1:0]                 col_reg;
    logic [RW-1:0]                 row_reg;
    logic [FXW-1:0]                fy_reg;
    logic                          row_ok_reg;

    logic [msb_pkg::COLOR_W-1:0]   frame_mem [DEPTH];
    logic [msb_pkg::COLOR_W-1:0]   rd_data_reg;

    logic                          out_valid_reg;
    logic [msb_pkg::PIXEL_W-1:0]   pixel_reg;
    logic                          oor_reg;

    logic [WB-1:0]  w_eff;
    logic [HB-1:0]  h_eff;
    logic [SB-1:0]  sw_eff;
    logic [SB-1:0]  sh_eff;
    logic [CB-1:0]  cols_eff;
    logic [RB-1:0]  rows_eff;
    logic [HB-1:0]  mul_a;
    logic [FXW-1:0] fx;
    logic           draw_we;
    logic           mem_we;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           in_range;

    // saturate the size registers to what the store and mask can hold
    always_comb
    begin
        w_eff  = (32'(fb_width_reg) > FB_MAX_WIDTH) ? WB'(FB_MAX_WIDTH) : WB'(fb_width_reg);
        h_eff  = (32'(fb_height_reg) > FB_MAX_HEIGHT) ? HB'(FB_MAX_HEIGHT)
                                                      : HB'(fb_height_reg);
        sw_eff = (32'(spr_width_reg) > SPRITE_MAX) ? SB'(SPRITE_MAX) : SB'(spr_width_reg);
        sh_eff = (32'(spr_height_reg) > SPRITE_MAX) ? SB'(SPRITE_MAX) : SB'(spr_height_reg);
        // columns past the mask word and rows past the loadable ones never draw
        cols_eff = (32'(sw_eff) > msb_pkg::MASK_COLS) ? CB'(msb_pkg::MASK_COLS) : CB'(sw_eff);
        rows_eff = (32'(sh_eff) > MASK_ROWS) ? RB'(MASK_ROWS) : RB'(sh_eff);
    end

    always_comb
    begin
        case (ctl.mul_sel)
            msb_pkg::MUL_FRAME: mul_a = h_eff;
            msb_pkg::MUL_ROW:   mul_a = HB'(fy_reg);
            msb_pkg::MUL_READ:  mul_a = HB'(y_reg);
            default:            mul_a = h_eff;
        endcase
    end

    assign fx       = FXW'(x_reg) + FXW'(col_reg);
    assign in_range = (32'(x_reg) < 32'(w_eff)) && (32'(y_reg) < 32'(h_eff));
    assign draw_we  = ctl.col_step && row_ok_reg && mask_reg[row_reg][col_reg]
                      && (32'(fx) < 32'(w_eff));
    assign mem_we   = ctl.clr_step || draw_we;
    assign wr_addr  = ctl.clr_step ? clr_cnt_reg : AW'(prod_reg + PW'(fx));
    assign rd_addr  = AW'(prod_reg + PW'(x_reg));

    always_comb
    begin
        sts            = '0;
        sts.clr_empty  = (prod_reg == '0);
        sts.clr_last   = ((NW'(clr_cnt_reg) + NW'(1)) == NW'(prod_reg));
        sts.draw_empty = (cols_eff == '0) || (rows_eff == '0);
        sts.col_last   = ((CB'(col_reg) + CB'(1)) == cols_eff);
        sts.row_last   = ((RB'(row_reg) + RB'(1)) == rows_eff);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // configuration and mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg   <= msb_pkg::FB_WIDTH_RST;
            fb_height_reg  <= msb_pkg::FB_HEIGHT_RST;
            spr_width_reg  <= msb_pkg::SPRITE_W_RST;
            spr_height_reg <= msb_pkg::SPRITE_H_RST;
            for (int i = 0; i < MASK_ROWS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (msb_pkg::cfg_idx_t'(cfg_index))
                    msb_pkg::CFG_FB_WIDTH:   fb_width_reg   <= cfg_data;
                    msb_pkg::CFG_FB_HEIGHT:  fb_height_reg  <= cfg_data;
                    msb_pkg::CFG_SPR_WIDTH:  spr_width_reg  <= cfg_data[msb_pkg::SPR_DIM_W-1:0];
                    msb_pkg::CFG_SPR_HEIGHT: spr_height_reg <= cfg_data[msb_pkg::SPR_DIM_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.capture && (msb_pkg::cmd_t'(cmd) == msb_pkg::CMD_LOAD)
                && (32'(row_index) < MASK_ROWS))
            begin
                mask_reg[RW'(row_index)] <= row_bits;
            end
        end
    end

    // command capture, multiplier and sweep counters
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= msb_pkg::cmd_t'(cmd);
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            color_reg <= color_rgb;
        end
        if (ctl.mul_load)
        begin
            prod_reg <= PW'(mul_a) * PW'(w_eff);
        end
        if (ctl.mul_load && (ctl.mul_sel == msb_pkg::MUL_FRAME))
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
        if (ctl.drw_init)
        begin
            // first mask row lands on the highest frame row: start at pos_y + height - 1
            fy_reg  <= FXW'(y_reg) + FXW'(sh_eff) - FXW'(1);
            row_reg <= '0;
        end
        else if (ctl.row_step)
        begin
            fy_reg  <= fy_reg - FXW'(1);
            row_reg <= row_reg + RW'(1);
        end
        if (ctl.mul_load && (ctl.mul_sel == msb_pkg::MUL_ROW))
        begin
            col_reg    <= '0;
            row_ok_reg <= (32'(fy_reg) < 32'(h_eff));
        end
        else if (ctl.col_step)
        begin
            col_reg <= col_reg + CW'(1);
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= color_reg;
        end
        if (ctl.mem_rd)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            if ((cmd_reg == msb_pkg::CMD_READ) && in_range)
            begin
                pixel_reg <= {rd_data_reg, msb_pkg::ALPHA_FULL};
            end
            else
            begin
                pixel_reg <= '0;
            end
            oor_reg <= (cmd_reg == msb_pkg::CMD_READ) && !in_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_pixel   = pixel_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire
